[hdl/bemr_pkg.sv]
// shared types and constants for the big-endian memory with reservation
// used by bemr_ctrl, bemr_dpath and the top level; no dependencies
`default_nettype none

package bemr_pkg;

    // default memory size in bytes
    localparam int MEM_BYTES_DEF = 65536;

    // request type codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_STORE = 2'd1;
    localparam logic [1:0] REQ_LRSV  = 2'd2;
    localparam logic [1:0] REQ_STCD  = 2'd3;

    // cr0 values written by a store-conditional
    localparam logic [3:0] CR0_EQ   = 4'd2;
    localparam logic [3:0] CR0_NONE = 4'd0;

    // controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECIDE,
        S_READ,
        S_DRAIN,
        S_WRITE,
        S_FINISH
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic accept;    // latch a new request beat
        logic clr_wr;    // write zero at the clear pointer
        logic rd_en;     // read the current byte
        logic wr_en;     // write the current byte
        logic load_out;  // load result registers and commit state
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic clr_last;   // clear pointer at the last byte
        logic do_read;    // request succeeds and reads memory
        logic do_write;   // request succeeds and writes memory
        logic last_byte;  // byte counter at the last byte of the access
    } t_status;

endpackage

`default_nettype wire

[hdl/bemr_ctrl.sv]
// controller state machine: clearing pass, request sequencing, result handoff
// depends on bemr_pkg
`default_nettype none

module bemr_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    input  bemr_pkg::t_status  i_status,
    output bemr_pkg::t_cmd     o_cmd
);

    bemr_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bemr_pkg::S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            bemr_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) n_state = bemr_pkg::S_IDLE;
            end
            bemr_pkg::S_IDLE: begin
                o_cmd.accept = i_in_valid;
                if (i_in_valid) n_state = bemr_pkg::S_DECIDE;
            end
            bemr_pkg::S_DECIDE: begin
                if (i_status.do_read)       n_state = bemr_pkg::S_READ;
                else if (i_status.do_write) n_state = bemr_pkg::S_WRITE;
                else                        n_state = bemr_pkg::S_FINISH;
            end
            bemr_pkg::S_READ: begin
                o_cmd.rd_en = 1'b1;
                if (i_status.last_byte) n_state = bemr_pkg::S_DRAIN;
            end
            bemr_pkg::S_DRAIN: begin
                n_state = bemr_pkg::S_FINISH;
            end
            bemr_pkg::S_WRITE: begin
                o_cmd.wr_en = 1'b1;
                if (i_status.last_byte) n_state = bemr_pkg::S_FINISH;
            end
            bemr_pkg::S_FINISH: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = bemr_pkg::S_IDLE;
                end
            end
            default: n_state = bemr_pkg::S_CLEAR;
        endcase
    end

    // result beat held until taken
    always_comb begin
        if (o_cmd.load_out)   n_out_valid = 1'b1;
        else if (!i_out_stall) n_out_valid = 1'b0;
        else                  n_out_valid = r_out_valid;
    end

    assign o_in_stall  = (r_state != bemr_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

    // no result may appear before the clearing pass is done
    a_no_out_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bemr_pkg::S_CLEAR) |-> !r_out_valid)
        else $error("result valid during clearing pass");

    // read and write never issued together
    a_rd_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.rd_en && o_cmd.wr_en))
        else $error("read and write in the same cycle");

    // a result never overwrites one that is still stalled
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a stalled beat");

    // an accepted request goes straight to the decision step
    a_accept_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == bemr_pkg::S_DECIDE))
        else $error("accept not followed by decide");

endmodule

`default_nettype wire

[hdl/bemr_dpath.sv]
// datapath: request registers, byte-wide memory, reservation, cr0, results
// depends on bemr_pkg
`default_nettype none

module bemr_dpath #(
    parameter int MEM_BYTES = bemr_pkg::MEM_BYTES_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire  [1:0]         i_req_type,
    input  wire  [1:0]         i_size_log2,
    input  wire  [31:0]        i_address,
    input  wire  [63:0]        i_write_data,
    input  bemr_pkg::t_cmd     i_cmd,
    output bemr_pkg::t_status  o_status,
    output logic               o_ok,
    output logic [63:0]        o_read_data,
    output logic [3:0]         o_cond_field
);

    localparam int          AW      = $clog2(MEM_BYTES);
    localparam logic [32:0] MEM_LIM = 33'(MEM_BYTES);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);

    // request registers
    logic [1:0]  r_type;
    logic [1:0]  r_szl;
    logic [31:0] r_addr;
    logic [63:0] r_wdata;

    // sequencing
    logic [2:0]    r_cnt;
    logic [AW-1:0] r_clr_addr;
    logic          r_pend;
    logic [63:0]   r_acc;

    // memory
    logic [7:0]    r_mem [MEM_BYTES];
    logic [7:0]    r_mem_q;

    // architectural state
    logic [31:0] r_resv_addr, n_resv_addr;
    logic        r_resv_valid, n_resv_valid;
    logic [3:0]  r_cr0, n_cr0;

    // result registers
    logic        r_ok;
    logic [63:0] r_rdata;
    logic [3:0]  r_cond;

    logic [2:0]    mask;
    logic [3:0]    len;
    logic [32:0]   end_addr;
    logic          in_rng;
    logic          aligned;
    logic          resv_match;
    logic          overlap;
    logic          ok;
    logic [AW-1:0] byte_addr;
    logic [AW-1:0] wr_addr;
    logic [2:0]    wsel;
    logic [7:0]    wbyte;
    logic          mem_wr;

    // size decode
    always_comb begin
        unique case (r_szl)
            2'd0:    mask = 3'd0;
            2'd1:    mask = 3'd1;
            2'd2:    mask = 3'd3;
            default: mask = 3'd7;
        endcase
    end

    assign len        = {1'b0, mask} + 4'd1;
    assign end_addr   = {1'b0, r_addr} + 33'(len);
    assign in_rng     = (end_addr <= MEM_LIM);
    assign aligned    = ((r_addr[2:0] & mask) == 3'd0);
    assign resv_match = r_resv_valid && (r_resv_addr == r_addr);
    assign overlap    = ({1'b0, r_addr} < ({1'b0, r_resv_addr} + 33'd8))
                        && ({1'b0, r_resv_addr} < end_addr);

    // success per request type
    always_comb begin
        unique case (r_type) inside
            bemr_pkg::REQ_LOAD, bemr_pkg::REQ_STORE: ok = in_rng;
            bemr_pkg::REQ_LRSV: ok = r_szl[1] && aligned && in_rng;
            default:            ok = r_szl[1] && aligned && resv_match && in_rng;
        endcase
    end

    assign o_status.clr_last  = (r_clr_addr == CLR_LAST);
    assign o_status.do_read   = ok && (r_type == bemr_pkg::REQ_LOAD
                                       || r_type == bemr_pkg::REQ_LRSV);
    assign o_status.do_write  = ok && (r_type == bemr_pkg::REQ_STORE
                                       || r_type == bemr_pkg::REQ_STCD);
    assign o_status.last_byte = (r_cnt == mask);

    // request latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_type  <= i_req_type;
            r_szl   <= i_size_log2;
            r_addr  <= i_address;
            r_wdata <= i_write_data;
        end
    end

    // byte counter, clear pointer and read pending flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_clr_addr <= '0;
            r_pend     <= 1'b0;
        end else begin
            r_pend <= i_cmd.rd_en;
            if (i_cmd.accept) r_cnt <= '0;
            else if (i_cmd.rd_en || i_cmd.wr_en) r_cnt <= r_cnt + 3'd1;
            if (i_cmd.clr_wr) r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // big-endian byte placement: first address takes the top stored byte
    assign byte_addr = r_addr[AW-1:0] + AW'(r_cnt);
    assign wsel      = mask - r_cnt;
    assign wbyte     = i_cmd.clr_wr ? 8'd0 : r_wdata[{wsel, 3'b000} +: 8];
    assign wr_addr   = i_cmd.clr_wr ? r_clr_addr : byte_addr;
    assign mem_wr    = i_cmd.clr_wr || i_cmd.wr_en;

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (mem_wr) r_mem[wr_addr] <= wbyte;
        if (i_cmd.rd_en) r_mem_q <= r_mem[byte_addr];
    end

    // load assembly, most significant byte first
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_acc <= '0;
        else if (r_pend)  r_acc <= {r_acc[55:0], r_mem_q};
    end

    // reservation and cr0 update
    always_comb begin
        n_resv_addr  = r_resv_addr;
        n_resv_valid = r_resv_valid;
        n_cr0        = r_cr0;
        case (r_type)
            bemr_pkg::REQ_STORE: begin
                if (ok && overlap) n_resv_valid = 1'b0;
            end
            bemr_pkg::REQ_LRSV: begin
                if (ok) begin
                    n_resv_addr  = r_addr;
                    n_resv_valid = 1'b1;
                end
            end
            bemr_pkg::REQ_STCD: begin
                if (r_szl[1]) begin
                    n_resv_valid = 1'b0;
                    n_cr0        = ok ? bemr_pkg::CR0_EQ : bemr_pkg::CR0_NONE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resv_addr  <= '0;
            r_resv_valid <= 1'b0;
            r_cr0        <= '0;
        end else if (i_cmd.load_out) begin
            r_resv_addr  <= n_resv_addr;
            r_resv_valid <= n_resv_valid;
            r_cr0        <= n_cr0;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_ok    <= ok;
            r_rdata <= r_acc;
            r_cond  <= n_cr0;
        end
    end

    assign o_ok         = r_ok;
    assign o_read_data  = r_rdata;
    assign o_cond_field = r_cond;

endmodule

`default_nettype wire

[hdl/big_endian_memory_with_reservation.sv]
// Big-endian byte memory with a single load-reserve / store-conditional
// reservation. After reset the block runs a clearing pass, one byte per cycle,
// with o_in_stall high. The memory has one byte-wide port, so a request moves
// one byte per cycle. A request passes a decision step, write steps (store or
// successful store-conditional) or read steps and a drain step (load or
// load-reserve) if it touches memory, then a finish step that waits for a free
// output; o_in_stall stays high until then. A finished result waits in its own
// register while the next request is taken. Loads return the value with the
// lowest address as the most significant byte, zero-extended.
// depends on bemr_pkg, bemr_ctrl, bemr_dpath
`default_nettype none

module big_endian_memory_with_reservation #(
    parameter int MEM_BYTES = bemr_pkg::MEM_BYTES_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_req_type,
    input  wire  [1:0]  i_size_log2,
    input  wire  [31:0] i_address,
    input  wire  [63:0] i_write_data,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_ok,
    output logic [63:0] o_read_data,
    output logic [3:0]  o_cond_field
);

    bemr_pkg::t_cmd    cmd;
    bemr_pkg::t_status status;

    // sequencing
    bemr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // storage and result logic
    bemr_dpath #(
        .MEM_BYTES (MEM_BYTES)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_type   (i_req_type),
        .i_size_log2  (i_size_log2),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_ok         (o_ok),
        .o_read_data  (o_read_data),
        .o_cond_field (o_cond_field)
    );

endmodule

`default_nettype wire

[test/big_endian_memory_with_reservation_test.sv]
// self-checking testbench for big_endian_memory_with_reservation
// holds a shadow memory and reservation that predict every reply beat
// depends on bemr_pkg and the block's top level only
`timescale 1ns / 1ps

module big_endian_memory_with_reservation_test;

    // access size codes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;
    localparam logic [1:0] SZ_DBL  = 2'd3;

    localparam int MEM_SIZE   = bemr_pkg::MEM_BYTES_DEF;
    localparam int STALL_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 24;

    typedef struct packed {
        logic        ok;
        logic [63:0] rdata;
        logic [3:0]  cond;
    } t_reply;

    // shadow of the guest memory, the reservation and cr0
    class bemr_shadow;
        bit [7:0]  image [MEM_SIZE];
        bit [31:0] resv_base;
        bit        resv_live;
        bit [3:0]  cr0;
        t_reply    replies_due [$];
        int        errors;

        function new();
            foreach (image[i]) image[i] = 8'h00;
            resv_base = 32'd0;
            resv_live = 1'b0;
            cr0 = bemr_pkg::CR0_NONE;
            errors = 0;
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10) $display("%0t: %s", $time, msg);
        endfunction

        function bit fits(bit [31:0] addr, bit [63:0] len);
            return ({32'd0, addr} + len) <= 64'(MEM_SIZE);
        endfunction

        function bit [63:0] read_be(bit [31:0] addr, bit [63:0] len);
            bit [63:0] v;
            v = 64'd0;
            for (int i = 0; i < len; i++) v = (v << 8) | 64'(image[addr + i]);
            return v;
        endfunction

        function void write_be(bit [31:0] addr, bit [63:0] len, bit [63:0] v);
            for (int i = 0; i < len; i++) image[addr + len - 1 - i] = v[8*i +: 8];
        endfunction

        // work out the reply of one accepted request beat
        function void note_request(bit [1:0] kind, bit [1:0] szl, bit [31:0] addr,
                                   bit [63:0] wdata);
            bit [63:0] len;
            bit [31:0] amask;
            bit        hit;
            t_reply    r;
            len = 64'd1 << szl;
            amask = 32'(len - 1);
            r.ok = 1'b0;
            r.rdata = 64'd0;
            case (kind)
                bemr_pkg::REQ_LOAD: begin
                    if (fits(addr, len)) begin
                        r.rdata = read_be(addr, len);
                        r.ok = 1'b1;
                    end
                end
                bemr_pkg::REQ_STORE: begin
                    if (fits(addr, len)) begin
                        // a plain store over the reserved granule drops it
                        if (resv_live && {32'd0, addr} < {32'd0, resv_base} + 64'd8 &&
                            {32'd0, resv_base} < {32'd0, addr} + len)
                            resv_live = 1'b0;
                        write_be(addr, len, wdata);
                        r.ok = 1'b1;
                    end
                end
                bemr_pkg::REQ_LRSV: begin
                    if (szl >= SZ_WORD && (addr & amask) == 0 && fits(addr, len)) begin
                        r.rdata = read_be(addr, len);
                        resv_base = addr;
                        resv_live = 1'b1;
                        r.ok = 1'b1;
                    end
                end
                default: begin
                    // small conditional stores have no effect at all
                    if (szl >= SZ_WORD) begin
                        hit = (addr & amask) == 0 && resv_live && resv_base == addr;
                        resv_live = 1'b0;
                        if (hit && fits(addr, len)) begin
                            write_be(addr, len, wdata);
                            r.ok = 1'b1;
                        end
                        cr0 = r.ok ? bemr_pkg::CR0_EQ : bemr_pkg::CR0_NONE;
                    end
                end
            endcase
            r.cond = cr0;
            replies_due.push_back(r);
        endfunction

        // compare one reply beat with the oldest prediction
        function void check_reply(logic ok, logic [63:0] rdata, logic [3:0] cond);
            t_reply want;
            if (replies_due.size() == 0) begin
                flag($sformatf("unexpected reply ok=%b rdata=%h cond=%h", ok, rdata, cond));
                return;
            end
            want = replies_due.pop_front();
            if (ok !== want.ok || rdata !== want.rdata || cond !== want.cond)
                flag($sformatf({"reply mismatch: exp ok=%b rdata=%h cond=%h, ",
                                "got ok=%b rdata=%h cond=%h"},
                               want.ok, want.rdata, want.cond, ok, rdata, cond));
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_req_type;
    logic [1:0]  i_size_log2;
    logic [31:0] i_address;
    logic [63:0] i_write_data;
    logic        o_out_valid;
    logic        i_out_stall = 1'b1;
    logic        o_ok;
    logic [63:0] o_read_data;
    logic [3:0]  o_cond_field;

    bemr_shadow board = new();
    int send_idle_pct = 9;
    int recv_idle_pct = 70;
    int beats_sent = 0;
    int quiet_cycles = 0;

    big_endian_memory_with_reservation uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_size_log2  (i_size_log2),
        .i_address    (i_address),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_ok         (o_ok),
        .o_read_data  (o_read_data),
        .o_cond_field (o_cond_field)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // reply side: check accepted beats, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_reply(o_ok, o_read_data, o_cond_field);
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog on cycles with no beat on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("big_endian_memory_with_reservation_test: FAIL");
            $finish;
        end
    end

    // present one request beat and wait until it is taken
    task automatic drive_req(input logic [1:0] kind, input logic [1:0] szl,
                             input logic [31:0] addr, input logic [63:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_req_type   <= kind;
        i_size_log2  <= szl;
        i_address    <= addr;
        i_write_data <= data;
        do @(posedge i_clk); while (o_in_stall);
        board.note_request(kind, szl, addr, data);
        beats_sent++;
    endtask

    // hold off the sender until every reply is back
    task automatic drain_replies();
        i_in_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // addresses biased to a small window and the memory end
    function automatic logic [31:0] pick_addr();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50) return $urandom_range(255);
        if (sel < 70) return $urandom_range(MEM_SIZE + 7, MEM_SIZE - 16);
        if (sel < 85) return $urandom;
        return $urandom_range(MEM_SIZE - 1);
    endfunction

    function automatic logic [63:0] pick_data();
        return {$urandom, $urandom};
    endfunction

    // reserve, up to two other accesses, then a conditional store
    task automatic resv_sequence();
        logic [1:0]  szl;
        logic [31:0] base;
        logic [31:0] sc_addr;
        logic [1:0]  sc_szl;
        int          n;
        szl = 2'($urandom_range(3, 2));
        base = pick_addr() & ~((32'd1 << szl) - 1);
        drive_req(bemr_pkg::REQ_LRSV, szl, base, pick_data());
        n = $urandom_range(2);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(1))
                drive_req(2'($urandom_range(3)), 2'($urandom_range(3)),
                          base - 4 + $urandom_range(15), pick_data());
            else
                drive_req(2'($urandom_range(3)), 2'($urandom_range(3)),
                          pick_addr(), pick_data());
        end
        sc_szl = ($urandom_range(9) == 0) ? 2'($urandom_range(1)) : 2'($urandom_range(3, 2));
        sc_addr = ($urandom_range(4) == 0) ? base + $urandom_range(8, 1) : base;
        drive_req(bemr_pkg::REQ_STCD, sc_szl, sc_addr, pick_data());
    endtask

    task automatic random_traffic(input int count);
        int stop_at;
        stop_at = beats_sent + count;
        while (beats_sent < stop_at) begin
            if ($urandom_range(99) < 40)
                resv_sequence();
            else
                drive_req(2'($urandom_range(3)), 2'($urandom_range(3)),
                          pick_addr(), pick_data());
        end
    endtask

    task automatic directed_checks();
        // cleared memory and the size variants of a load
        drive_req(bemr_pkg::REQ_LOAD,  SZ_DBL,  32'd0, 64'd0);
        drive_req(bemr_pkg::REQ_STORE, SZ_DBL,  32'd0, 64'h0123_4567_89ab_cdef);
        drive_req(bemr_pkg::REQ_LOAD,  SZ_BYTE, 32'd0, 64'd0);
        drive_req(bemr_pkg::REQ_LOAD,  SZ_HALF, 32'd1, 64'd0);
        drive_req(bemr_pkg::REQ_LOAD,  SZ_WORD, 32'd3, 64'd0);
        drive_req(bemr_pkg::REQ_LOAD,  SZ_DBL,  32'd0, 64'd0);
        // memory end and out of range
        drive_req(bemr_pkg::REQ_STORE, SZ_DBL,  MEM_SIZE - 8, 64'hffff_ffff_ffff_ffff);
        drive_req(bemr_pkg::REQ_LOAD,  SZ_BYTE, MEM_SIZE - 1, 64'd0);
        drive_req(bemr_pkg::REQ_LOAD,  SZ_HALF, MEM_SIZE - 1, 64'd0);
        drive_req(bemr_pkg::REQ_STORE, SZ_BYTE, MEM_SIZE, 64'hffff_ffff_ffff_ffff);
        drive_req(bemr_pkg::REQ_LOAD,  SZ_DBL,  32'hffff_ffff, 64'd0);
        // misaligned and small reserve or conditional
        drive_req(bemr_pkg::REQ_LRSV,  SZ_WORD, 32'd2, 64'd0);
        drive_req(bemr_pkg::REQ_LRSV,  SZ_BYTE, 32'd8, 64'd0);
        drive_req(bemr_pkg::REQ_STCD,  SZ_HALF, 32'd8, 64'hffff_ffff_ffff_ffff);
        // reserve and conditional store, then a second one that fails
        drive_req(bemr_pkg::REQ_LRSV,  SZ_DBL,  32'd16, 64'd0);
        drive_req(bemr_pkg::REQ_STCD,  SZ_DBL,  32'd16, 64'hfedc_ba98_7654_3210);
        drive_req(bemr_pkg::REQ_STCD,  SZ_DBL,  32'd16, 64'd0);
        // a store inside the granule kills the reservation
        drive_req(bemr_pkg::REQ_LRSV,  SZ_WORD, 32'd32, 64'd0);
        drive_req(bemr_pkg::REQ_STORE, SZ_BYTE, 32'd39, 64'h5a);
        drive_req(bemr_pkg::REQ_STCD,  SZ_WORD, 32'd32, 64'h1111_2222);
        // store outside the granule, a load, mixed sizes
        drive_req(bemr_pkg::REQ_LRSV,  SZ_WORD, 32'd40, 64'd0);
        drive_req(bemr_pkg::REQ_STORE, SZ_DBL,  32'd48, 64'h0);
        drive_req(bemr_pkg::REQ_LOAD,  SZ_DBL,  32'd40, 64'd0);
        drive_req(bemr_pkg::REQ_STCD,  SZ_DBL,  32'd40, 64'haaaa_5555_aaaa_5555);
        // misaligned conditional store clears a live reservation
        drive_req(bemr_pkg::REQ_LRSV,  SZ_DBL,  MEM_SIZE - 8, 64'd0);
        drive_req(bemr_pkg::REQ_STCD,  SZ_WORD, MEM_SIZE - 6, 64'd0);
        drive_req(bemr_pkg::REQ_STCD,  SZ_DBL,  MEM_SIZE - 8, 64'h0);
    endtask

    // stimulus and end of run
    initial begin
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_req_type   <= bemr_pkg::REQ_LOAD;
        i_size_log2  <= SZ_BYTE;
        i_address    <= 32'd0;
        i_write_data <= 64'd0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        directed_checks();
        random_traffic(320);
        drain_replies();

        send_idle_pct = 70;
        recv_idle_pct = 9;
        random_traffic(350);
        drain_replies();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_traffic(175);
        drain_replies();
        random_traffic(175);
        drain_replies();

        if (board.pending() != 0) board.flag("replies still outstanding at end of run");
        if (board.errors == 0) begin
            $display("big_endian_memory_with_reservation_test: PASS");
        end else begin
            $display("big_endian_memory_with_reservation_test: FAIL");
        end
        $finish;
    end

endmodule
